// File: rtl/core/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Types and widths shared by the segment intersection core and its stages.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CW = 16;          // coordinate width, signed Q12.4
    localparam int DW = CW + 1;      // coordinate difference
    localparam int PW = 2 * DW;      // cross product term
    localparam int XW = PW + 1;      // den / tnum / unum, signed
    localparam int MW = XW;          // magnitude of a cross value
    localparam int NW = MW + DW;     // dividend |tnum| * |delta|
    localparam int QW = DW;          // quotient bits, one per divider cell

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } ssi_in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
    } ssi_out_t;

    typedef struct packed {
        logic [NW-1:0]        rem;
        logic [QW-1:0]        quo;
        logic                 neg;
        logic signed [CW-1:0] base;
    } ssi_lane_t;

    typedef struct packed {
        logic          valid;
        logic          hit;
        logic [MW-1:0] den;
        ssi_lane_t     lx;
        ssi_lane_t     ly;
    } ssi_div_t;

endpackage

// File: rtl/core/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front
// Differences, cross products, hit test and dividend products, five stages.
// ----------------------------------------------------------------------------
module ssi_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  ssi_pkg::ssi_in_t seg_in,
    output ssi_pkg::ssi_div_t div_out
);
    import ssi_pkg::*;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] d12x_reg, d12y_reg, d34x_reg, d34y_reg, d13x_reg, d13y_reg;
    logic signed [CW-1:0] bx1_reg, by1_reg;
    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [DW-1:0] d12x2_reg, d12y2_reg;
    logic signed [CW-1:0] bx2_reg, by2_reg;
    // stage 3: cross values
    logic                 v3_reg;
    logic signed [XW-1:0] den_reg, tnum_reg, unum_reg;
    logic signed [DW-1:0] d12x3_reg, d12y3_reg;
    logic signed [CW-1:0] bx3_reg, by3_reg;
    // stage 4: magnitudes and hit
    logic                 v4_reg, hit4_reg, negx4_reg, negy4_reg;
    logic [MW-1:0]        tm_reg, dm_reg;
    logic [DW-1:0]        adx_reg, ady_reg;
    logic signed [CW-1:0] bx4_reg, by4_reg;
    // stage 5
    logic                 v5_reg;
    ssi_div_t             out_reg;

    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        sx = {v[CW-1], v};
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] v);
        mag = v[XW-1] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic [DW-1:0] dmag(input logic signed [DW-1:0] v);
        dmag = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [MW-1:0] tm_c, um_c, dm_c;
    logic          tin_c, uin_c, hit_c;

    always_comb
    begin
        tm_c  = mag(tnum_reg);
        um_c  = mag(unum_reg);
        dm_c  = mag(den_reg);
        tin_c = ((tnum_reg == '0) || (tnum_reg[XW-1] == den_reg[XW-1])) && (tm_c <= dm_c);
        uin_c = ((unum_reg == '0) || (unum_reg[XW-1] == den_reg[XW-1])) && (um_c <= dm_c);
        hit_c = (den_reg != '0) && tin_c && uin_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d12x_reg <= sx(seg_in.a_start_x) - sx(seg_in.a_end_x);
        d12y_reg <= sx(seg_in.a_start_y) - sx(seg_in.a_end_y);
        d34x_reg <= sx(seg_in.b_start_x) - sx(seg_in.b_end_x);
        d34y_reg <= sx(seg_in.b_start_y) - sx(seg_in.b_end_y);
        d13x_reg <= sx(seg_in.a_start_x) - sx(seg_in.b_start_x);
        d13y_reg <= sx(seg_in.a_start_y) - sx(seg_in.b_start_y);
        bx1_reg  <= seg_in.a_start_x;
        by1_reg  <= seg_in.a_start_y;

        p1_reg    <= d12x_reg * d34y_reg;
        p2_reg    <= d12y_reg * d34x_reg;
        p3_reg    <= d13x_reg * d34y_reg;
        p4_reg    <= d13y_reg * d34x_reg;
        p5_reg    <= d13x_reg * d12y_reg;
        p6_reg    <= d13y_reg * d12x_reg;
        d12x2_reg <= d12x_reg;
        d12y2_reg <= d12y_reg;
        bx2_reg   <= bx1_reg;
        by2_reg   <= by1_reg;

        den_reg   <= {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};
        tnum_reg  <= {p3_reg[PW-1], p3_reg} - {p4_reg[PW-1], p4_reg};
        unum_reg  <= {p5_reg[PW-1], p5_reg} - {p6_reg[PW-1], p6_reg};
        d12x3_reg <= d12x2_reg;
        d12y3_reg <= d12y2_reg;
        bx3_reg   <= bx2_reg;
        by3_reg   <= by2_reg;

        // delta along A is the negated difference: positive when d12 < 0
        hit4_reg  <= hit_c;
        tm_reg    <= tm_c;
        dm_reg    <= dm_c;
        adx_reg   <= dmag(d12x3_reg);
        ady_reg   <= dmag(d12y3_reg);
        negx4_reg <= tnum_reg[XW-1] ^ den_reg[XW-1] ^ ((d12x3_reg != '0) && !d12x3_reg[DW-1]);
        negy4_reg <= tnum_reg[XW-1] ^ den_reg[XW-1] ^ ((d12y3_reg != '0) && !d12y3_reg[DW-1]);
        bx4_reg   <= bx3_reg;
        by4_reg   <= by3_reg;

        out_reg.valid   <= v4_reg;
        out_reg.hit     <= hit4_reg;
        out_reg.den     <= dm_reg;
        out_reg.lx.rem  <= NW'(tm_reg) * NW'(adx_reg);
        out_reg.lx.quo  <= '0;
        out_reg.lx.neg  <= negx4_reg;
        out_reg.lx.base <= bx4_reg;
        out_reg.ly.rem  <= NW'(tm_reg) * NW'(ady_reg);
        out_reg.ly.quo  <= '0;
        out_reg.ly.neg  <= negy4_reg;
        out_reg.ly.base <= by4_reg;
    end

    // take the valid bit from the reset flop
    always_comb
    begin
        div_out       = out_reg;
        div_out.valid = v5_reg;
    end

endmodule

// File: rtl/core/ssi_div_cell.sv
// ----------------------------------------------------------------------------
// ssi_div_cell
// One restoring divider step for both lanes: resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module ssi_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ssi_pkg::ssi_div_t prev,
    output ssi_pkg::ssi_div_t next
);
    import ssi_pkg::*;

    logic          valid_reg;
    ssi_div_t      cell_reg;
    ssi_div_t      cell_next;
    logic [NW-1:0] dsh;

    always_comb
    begin
        dsh       = NW'(prev.den) << SHIFT;
        cell_next = prev;
        // subtract the shifted divisor where it fits, set the quotient bit
        if (prev.lx.rem >= dsh)
        begin
            cell_next.lx.rem        = prev.lx.rem - dsh;
            cell_next.lx.quo[SHIFT] = 1'b1;
        end
        if (prev.ly.rem >= dsh)
        begin
            cell_next.ly.rem        = prev.ly.rem - dsh;
            cell_next.ly.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_next.valid;
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // take the valid bit from the reset flop
    always_comb
    begin
        next       = cell_reg;
        next.valid = valid_reg;
    end

endmodule

// File: rtl/core/segment_segment_intersect_core.sv
// ----------------------------------------------------------------------------
// segment_segment_intersect_core
// Parametric segment/segment intersection in Q12.4 with exact hit test.
// ----------------------------------------------------------------------------
//  channel   signals                 direction  handshake
//  input     start, busy, seg_in     in         beat on start && !busy
//  result    done, result            out        beat on done, one cycle
//
//  One pair is taken every cycle; busy is always low.
//  A pair runs through 5 front stages, one divider cell per quotient
//  bit (17), and the output register.
//  Reset clears the valid bits along the chain; data stages are not reset.
//  The receiver cannot stall; every result is shown for one cycle.
// ----------------------------------------------------------------------------
module segment_segment_intersect_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssi_pkg::ssi_in_t  seg_in,
    output logic              done,
    output ssi_pkg::ssi_out_t result
);
    import ssi_pkg::*;

    ssi_div_t chain [QW+1];

    ssi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(start),
        .seg_in  (seg_in),
        .div_out (chain[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++)
        begin : g_cell
            ssi_div_cell #(.SHIFT(QW - 1 - gi)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .prev (chain[gi]),
                .next (chain[gi+1])
            );
        end
    endgenerate

    ssi_div_t      last;
    logic [DW:0]   sum_x, sum_y;
    logic          done_reg;
    ssi_out_t      result_reg;
    ssi_out_t      result_next;

    always_comb
    begin
        last  = chain[QW];
        sum_x = last.lx.neg ? ({{2{last.lx.base[CW-1]}}, last.lx.base} - {1'b0, last.lx.quo})
                            : ({{2{last.lx.base[CW-1]}}, last.lx.base} + {1'b0, last.lx.quo});
        sum_y = last.ly.neg ? ({{2{last.ly.base[CW-1]}}, last.ly.base} - {1'b0, last.ly.quo})
                            : ({{2{last.ly.base[CW-1]}}, last.ly.base} + {1'b0, last.ly.quo});
        result_next.hit   = last.hit;
        result_next.hit_x = last.hit ? sum_x[CW-1:0] : '0;
        result_next.hit_y = last.hit ? sum_y[CW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
